// ----- rtl/core/mgc_pkg.sv -----
// ----------------------------------------------------------------------------
// mgc_pkg
// Shared types and constants for the Montgomery constant generator.
// ----------------------------------------------------------------------------
package mgc_pkg;

   localparam int unsigned ModulusWidth  = 64;
   localparam int unsigned WordWidth     = 32;
   localparam int unsigned Doublings     = 128;
   localparam int unsigned OneStage      = 63;
   localparam int unsigned NewtonSteps   = 4;
   localparam int unsigned InverseStages = 2 * NewtonSteps;
   localparam int unsigned InverseTap    = Doublings - 1 - InverseStages;

   typedef logic [ModulusWidth-1:0] modulus_type;
   typedef logic [WordWidth-1:0]    word_type;

   // one stage of the doubling chain
   typedef struct packed {
      logic        valid;
      modulus_type modulus;
      modulus_type residue;
      modulus_type mont_one;
   } stage_type;

endpackage

// ----- rtl/core/mgc_req_if.sv -----
// ----------------------------------------------------------------------------
// mgc_req_if
// Request channel: one modulus per transaction.
// ----------------------------------------------------------------------------
interface mgc_req_if;
   logic                valid;
   logic                ready;
   mgc_pkg::modulus_type modulus;

   modport source (output valid, output modulus, input ready);
   modport sink   (input valid, input modulus, output ready);
endinterface

// ----------------------------------------------------------------------------
// mgc_rsp_if
// Response channel: the Montgomery constants of one modulus.
// ----------------------------------------------------------------------------
interface mgc_rsp_if;
   logic                 valid;
   logic                 ready;
   mgc_pkg::word_type    neg_inverse;
   mgc_pkg::modulus_type mont_one;
   mgc_pkg::modulus_type r_squared;
   logic                 modulus_ok;

   modport source (output valid, output neg_inverse, output mont_one,
                   output r_squared, output modulus_ok, input ready);
   modport sink   (input valid, input neg_inverse, input mont_one,
                   input r_squared, input modulus_ok, output ready);
endinterface

// ----- rtl/core/mgc_double_stage.sv -----
// ----------------------------------------------------------------------------
// mgc_double_stage
// One registered modular doubling: residue <- 2 * residue mod modulus.
// ----------------------------------------------------------------------------
module mgc_double_stage #(
   parameter bit SaveOne = 1'b0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  mgc_pkg::stage_type stage_in,
   output mgc_pkg::stage_type stage_out
);
   import mgc_pkg::*;

   stage_type   stage_ff;
   stage_type   stage_in_w;
   modulus_type gap;
   modulus_type doubled;

   // doubling without overflow: subtract the gap when it wraps past n
   always_comb begin
      gap     = stage_in.modulus - stage_in.residue;
      doubled = (stage_in.residue >= gap) ? (stage_in.residue - gap)
                                          : (stage_in.residue + stage_in.residue);
      stage_in_w         = stage_in;
      stage_in_w.residue = doubled;
      if (SaveOne) begin
         stage_in_w.mont_one = doubled;
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff.valid <= stage_in_w.valid;
      end
      if (enable) begin
         stage_ff.modulus  <= stage_in_w.modulus;
         stage_ff.residue  <= stage_in_w.residue;
         stage_ff.mont_one <= stage_in_w.mont_one;
      end
   end

   assign stage_out = stage_ff;

endmodule

// ----- rtl/core/mgc_inverse_pipe.sv -----
// ----------------------------------------------------------------------------
// mgc_inverse_pipe
// Newton iteration for -(n^-1) mod 2^32, one multiply per stage.
// ----------------------------------------------------------------------------
module mgc_inverse_pipe (
   input  logic              clock,
   input  logic              enable,
   input  mgc_pkg::word_type low_word,
   output mgc_pkg::word_type neg_inverse
);
   import mgc_pkg::*;

   word_type a_ff [InverseStages];
   word_type x_ff [InverseStages];
   word_type p_ff [InverseStages];

   // even stages form a*x, odd stages form x*(2+a*x)
   always_ff @(posedge clock) begin
      if (enable) begin
         a_ff[0] <= low_word;
         x_ff[0] <= low_word + word_type'(2);
         p_ff[0] <= low_word * (low_word + word_type'(2));
         for (int k = 1; k < InverseStages; k++) begin
            a_ff[k] <= a_ff[k-1];
            if (k % 2 == 1) begin
               x_ff[k] <= x_ff[k-1] * (word_type'(2) + p_ff[k-1]);
               p_ff[k] <= p_ff[k-1];
            end else begin
               x_ff[k] <= x_ff[k-1];
               p_ff[k] <= a_ff[k-1] * x_ff[k-1];
            end
         end
      end
   end

   assign neg_inverse = x_ff[InverseStages-1];

endmodule

// ----- rtl/core/montgomery_constant_generator.sv -----
// ----------------------------------------------------------------------------
// montgomery_constant_generator
// Montgomery constants (R = 2^64) for a stream of 64-bit moduli.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one modulus per transaction; rsp returns neg_inverse,
//   mont_one (2^64 mod n), r_squared (2^128 mod n) and modulus_ok (n odd).
//   A zero modulus yields zero remainders.
// Throughput: one transaction per cycle while rsp is not stalled. The
//   remainders come from a chain of 128 registered modular doublings
//   starting at 1 mod n; the tap after the 64th is mont_one. The inverse
//   is an 8-stage multiplier pipeline (four Newton steps) fed from the
//   chain 8 stages before its end.
// Reset: synchronous, clears every valid bit; the pipe comes up empty.
// Stall: when rsp is held off with a result waiting, the whole pipe freezes,
//   bubbles included, and req.ready drops in the same cycle; nothing is
//   lost or repeated.
// ----------------------------------------------------------------------------
module montgomery_constant_generator (
   input logic      clock,
   input logic      reset,
   mgc_req_if.sink  req,
   mgc_rsp_if.source rsp
);
   import mgc_pkg::*;

   stage_type chain [Doublings+1];
   logic      enable;
   word_type  inverse;

   assign enable    = rsp.ready || !chain[Doublings].valid;
   assign req.ready = enable;

   // chain entry: 1 mod n
   always_comb begin
      chain[0].valid    = req.valid;
      chain[0].modulus  = req.modulus;
      chain[0].residue  = (req.modulus > modulus_type'(1)) ? modulus_type'(1) : '0;
      chain[0].mont_one = '0;
   end

   // doubling chain
   for (genvar g = 0; g < Doublings; g++) begin : g_double
      mgc_double_stage #(.SaveOne(g == OneStage)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .stage_in  (chain[g]),
         .stage_out (chain[g+1])
      );
   end

   // inverse runs alongside the last stages
   mgc_inverse_pipe u_inverse (
      .clock       (clock),
      .enable      (enable),
      .low_word    (chain[InverseTap+1].modulus[WordWidth-1:0]),
      .neg_inverse (inverse)
   );

   assign rsp.valid       = chain[Doublings].valid;
   assign rsp.neg_inverse = inverse;
   assign rsp.mont_one    = chain[Doublings].mont_one;
   assign rsp.r_squared   = chain[Doublings].residue;
   assign rsp.modulus_ok  = chain[Doublings].modulus[0];

   // pipe is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp.valid)
      else $error("response valid after reset");

   // remainders stay below a nonzero modulus
   a_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (chain[Doublings].modulus != '0) |->
         (rsp.mont_one < chain[Doublings].modulus) &&
         (rsp.r_squared < chain[Doublings].modulus))
      else $error("remainder not reduced");

   // inverse checks out for an odd modulus
   a_inverse: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.modulus_ok |->
         (word_type'(chain[Doublings].modulus[WordWidth-1:0] * rsp.neg_inverse)
          == '1))
      else $error("bad negated inverse");

endmodule
